// File: hdl/lcs_length_engine_defines.svh
// Assertion macros used by the lcs length engine RTL.
`ifndef LCS_LENGTH_ENGINE_DEFINES_SVH
`define LCS_LENGTH_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/lcs_pkg.sv
// Shared constants and types of the lcs length engine.
package lcs_pkg;

   localparam int MAX_LEN = 64;
   localparam int COUNT_W = $clog2(MAX_LEN + 1);
   localparam int SCORE_W = COUNT_W;
   localparam int SYM_W   = 8;
   localparam int CMD_W   = 2;
   localparam int LEN_W   = 7;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_NAME    = 2'd0,
      CMD_JOURNAL = 2'd1,
      CMD_END     = 2'd2
   } cmd_type;

   // One journal character on its way down the row of cells.
   typedef struct packed {
      logic               valid;
      logic [SYM_W-1:0]   sym;
      logic [SCORE_W-1:0] left;
      logic [SCORE_W-1:0] diag;
   } token_type;

   // Per-cell control from the top level.
   typedef struct packed {
      logic active;
      logic load;
      logic clear;
   } cell_ctl_type;

endpackage

// File: hdl/lcs_cell.sv
// One cell of the scoring row: a stored name character and its score.
module lcs_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  lcs_pkg::cell_ctl_type        ctl,
   input  logic [lcs_pkg::SYM_W-1:0]    load_sym,
   input  logic [lcs_pkg::SCORE_W-1:0]  load_score,
   input  lcs_pkg::token_type           tok_in,
   output lcs_pkg::token_type           tok_out,
   output logic [lcs_pkg::SCORE_W-1:0]  score
);

   logic [lcs_pkg::SYM_W-1:0]   sym_ff;
   logic [lcs_pkg::SCORE_W-1:0] score_ff;
   logic [lcs_pkg::SCORE_W-1:0] score_in;
   lcs_pkg::token_type          pass_ff;
   lcs_pkg::token_type          pass_in;
   logic                        take;
   logic [lcs_pkg::SCORE_W-1:0] now;

   assign take = tok_in.valid && ctl.active;

   always_comb begin
      if (sym_ff == tok_in.sym) begin
         now = tok_in.diag + lcs_pkg::SCORE_W'(1);
      end else if (score_ff > tok_in.left) begin
         now = score_ff;
      end else begin
         now = tok_in.left;
      end
   end

   always_comb begin
      priority if (ctl.clear) begin
         score_in = '0;
      end else if (ctl.load) begin
         score_in = load_score;
      end else if (take) begin
         score_in = now;
      end else begin
         score_in = score_ff;
      end
   end

   // Hand on the new score as the next cell's left and the old one as its diagonal.
   always_comb begin
      pass_in.valid = take && !ctl.clear;
      pass_in.sym   = tok_in.sym;
      pass_in.left  = now;
      pass_in.diag  = score_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff      <= '0;
         pass_ff.valid <= 1'b0;
      end else begin
         score_ff      <= score_in;
         pass_ff.valid <= pass_in.valid;
      end
      pass_ff.sym  <= pass_in.sym;
      pass_ff.left <= pass_in.left;
      pass_ff.diag <= pass_in.diag;
      if (ctl.load) begin
         sym_ff <= load_sym;
      end
   end

   assign tok_out = pass_ff;
   assign score   = score_ff;

endmodule

// File: hdl/lcs_length_engine.sv
// Longest common subsequence length engine: a systolic row of scoring cells.
//
// Input stream (req_): one command per transfer. Name characters are stored one
// to a cell, up to 64; further ones are dropped and set the overflow flag.
// Journal characters enter the row back to back, one per cycle, and ripple down
// it one cell per cycle, each cell updating its score on the way.
// An end command returns one transfer on rsp_ with the score of the last name
// cell and the overflow flag, then clears the row for the next query.
// Journal characters are always taken in the cycle they are offered. A name or
// end command waits until the last journal character has passed the last
// stored cell. An end command also waits for the result register to be free.
// The result of an end command is valid in the cycle after its transfer.
// A stalled receiver holds the result; the block keeps taking journal and name
// characters meanwhile, and stalls only a further end command.
// Reset (synchronous, active high) empties the name, zeroes all scores and the
// overflow flag, and drops any pending result.
`include "lcs_length_engine_defines.svh"

module lcs_length_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [lcs_pkg::REQ_W-1:0]  req_tdata,  // [1:0] command, [9:2] symbol
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [lcs_pkg::RSP_W-1:0]  rsp_tdata   // [6:0] lcs_length, [7] overflow
);

   lcs_pkg::cmd_type               cmd;
   logic [lcs_pkg::SYM_W-1:0]      symbol;
   logic                           accept;
   logic                           journal_go;
   logic                           append_go;
   logic                           store_go;
   logic                           drop_go;
   logic                           end_go;
   logic                           full;
   logic                           cleared;

   logic [lcs_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [lcs_pkg::COUNT_W-1:0]    drain_ff, drain_in;
   logic                           overflow_ff, overflow_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lcs_pkg::RSP_W-1:0]      rsp_data_ff;

   lcs_pkg::token_type             tok_chain [0:lcs_pkg::MAX_LEN];
   lcs_pkg::cell_ctl_type          ctl [0:lcs_pkg::MAX_LEN-1];
   logic [lcs_pkg::SCORE_W-1:0]    score [0:lcs_pkg::MAX_LEN-1];
   logic [lcs_pkg::SCORE_W-1:0]    tail_score;

   assign cmd    = lcs_pkg::cmd_type'(req_tdata[lcs_pkg::CMD_W-1:0]);
   assign symbol = req_tdata[lcs_pkg::CMD_W +: lcs_pkg::SYM_W];
   assign full   = (count_ff == lcs_pkg::COUNT_W'(lcs_pkg::MAX_LEN));

   always_comb begin
      unique case (cmd)
         lcs_pkg::CMD_JOURNAL: req_tready = 1'b1;
         lcs_pkg::CMD_END:     req_tready = (drain_ff == '0) && (!rsp_valid_ff || rsp_tready);
         default:              req_tready = (drain_ff == '0);
      endcase
   end

   assign accept     = req_tvalid && req_tready;
   assign journal_go = accept && (cmd == lcs_pkg::CMD_JOURNAL);
   assign append_go  = accept && (cmd == lcs_pkg::CMD_NAME);
   assign store_go   = append_go && !full;
   assign drop_go    = append_go && full;
   assign end_go     = accept && (cmd == lcs_pkg::CMD_END);

   // Head of the row: a journal character enters with zero left and diagonal.
   assign tok_chain[0].valid = journal_go;
   assign tok_chain[0].sym   = symbol;
   assign tok_chain[0].left  = '0;
   assign tok_chain[0].diag  = '0;

   always_comb begin
      for (int i = 0; i < lcs_pkg::MAX_LEN; i++) begin
         ctl[i].active = (lcs_pkg::COUNT_W'(i) < count_ff);
         ctl[i].load   = store_go && (lcs_pkg::COUNT_W'(i) == count_ff);
         ctl[i].clear  = end_go;
      end
   end

   // Score of the last stored cell; zero while the name is empty.
   always_comb begin
      tail_score = '0;
      for (int i = 0; i < lcs_pkg::MAX_LEN; i++) begin
         if (lcs_pkg::COUNT_W'(i + 1) == count_ff) begin
            tail_score = tail_score | score[i];
         end
      end
   end

   for (genvar g = 0; g < lcs_pkg::MAX_LEN; g++) begin : g_cell
      lcs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[g]),
         .load_sym   (symbol),
         .load_score (tail_score),
         .tok_in     (tok_chain[g]),
         .tok_out    (tok_chain[g+1]),
         .score      (score[g])
      );
   end

   // Track how long the newest journal character still needs to reach the last cell.
   always_comb begin
      if (journal_go) begin
         drain_in = (count_ff == '0) ? '0 : count_ff - lcs_pkg::COUNT_W'(1);
      end else if (drain_ff != '0) begin
         drain_in = drain_ff - lcs_pkg::COUNT_W'(1);
      end else begin
         drain_in = drain_ff;
      end
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (end_go) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (append_go) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + lcs_pkg::COUNT_W'(1);
         end
      end
   end

   always_comb begin
      if (end_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drain_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_go) begin
         rsp_data_ff <= {overflow_ff, lcs_pkg::LEN_W'(tail_score)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cleared = rsp_valid_ff && (count_ff == '0) && !overflow_ff;

   `LCS_ASSERT_NEXT(a_end_clears, end_go, cleared, "end transfer did not clear the query")
   `LCS_ASSERT_NEXT(a_append_grows, store_go, count_ff == $past(count_ff) + lcs_pkg::COUNT_W'(1), "count stuck")
   `LCS_ASSERT_NEXT(a_drop_flags, drop_go, overflow_ff && (count_ff == $past(count_ff)), "drop not flagged")
   `LCS_ASSERT_NOW(a_row_end, tok_chain[lcs_pkg::MAX_LEN].valid, full, "journal ran past the name")

endmodule

// File: test/lcs_length_engine_test.sv
// Self-checking testbench for the lcs length engine: directed table, then random queries.
module lcs_length_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lcs_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1030;
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 2 * lcs_pkg::MAX_LEN + 8;

   typedef struct packed {
      logic [lcs_pkg::LEN_W-1:0] len;
      logic                      ovf;
   } lcs_result_type;

   typedef struct packed {
      logic [lcs_pkg::CMD_W-1:0] cmd;
      logic [lcs_pkg::SYM_W-1:0] sym;
      logic                      typed;
      lcs_result_type            res;
   } query_item_type;

   typedef struct packed {
      logic [lcs_pkg::CMD_W-1:0] cmd;
      logic [lcs_pkg::SYM_W-1:0] sym;
      logic [7:0]                reps;
      logic                      typed;
      lcs_result_type            res;
   } dir_row_type;

   typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_TOGGLE} ready_pattern_type;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [lcs_pkg::REQ_W-1:0] req_tdata  = '0;   // [1:0] command, [9:2] symbol
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [lcs_pkg::RSP_W-1:0] rsp_tdata;         // [6:0] lcs_length, [7] overflow

   // Directed rows: typed results only where they are obvious.
   dir_row_type directed [25] = '{
      '{lcs_pkg::CMD_END,     8'h00, 8'd1,  1'b1, '{7'd0,  1'b0}},   // fresh from reset
      '{CMD_SPARE,            8'hFF, 8'd1,  1'b0, '{7'd0,  1'b0}},   // unused command
      '{lcs_pkg::CMD_END,     8'h00, 8'd1,  1'b1, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_JOURNAL, 8'h00, 8'd1,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_END,     8'h00, 8'd1,  1'b1, '{7'd0,  1'b0}},   // empty name
      '{lcs_pkg::CMD_NAME,    8'h00, 8'd1,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_END,     8'hFF, 8'd1,  1'b1, '{7'd0,  1'b0}},   // empty journal
      '{lcs_pkg::CMD_NAME,    8'hFF, 8'd1,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_JOURNAL, 8'hFF, 8'd1,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_END,     8'h00, 8'd1,  1'b1, '{7'd1,  1'b0}},
      '{lcs_pkg::CMD_NAME,    8'h55, 8'd65, 1'b0, '{7'd0,  1'b0}},   // one past capacity
      '{lcs_pkg::CMD_JOURNAL, 8'h55, 8'd3,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_END,     8'h00, 8'd1,  1'b1, '{7'd3,  1'b1}},
      '{lcs_pkg::CMD_NAME,    8'hAA, 8'd64, 1'b0, '{7'd0,  1'b0}},   // exactly full
      '{lcs_pkg::CMD_JOURNAL, 8'hAA, 8'd64, 1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_END,     8'h00, 8'd1,  1'b1, '{7'd64, 1'b0}},
      '{lcs_pkg::CMD_NAME,    8'h61, 8'd1,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_JOURNAL, 8'h62, 8'd1,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_NAME,    8'h62, 8'd1,  1'b0, '{7'd0,  1'b0}},   // late name, no match
      '{lcs_pkg::CMD_END,     8'h00, 8'd1,  1'b1, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_NAME,    8'h0F, 8'd1,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_JOURNAL, 8'hF0, 8'd2,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_NAME,    8'hF0, 8'd1,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_JOURNAL, 8'hF0, 8'd1,  1'b0, '{7'd0,  1'b0}},
      '{lcs_pkg::CMD_END,     8'h00, 8'd1,  1'b0, '{7'd0,  1'b0}}
   };

   query_item_type job_list [$];
   lcs_result_type pending_lengths [$];

   // Scoring state of the predictor.
   logic [lcs_pkg::SYM_W-1:0]   name_chars [lcs_pkg::MAX_LEN];
   logic [lcs_pkg::SCORE_W-1:0] cell_score [lcs_pkg::MAX_LEN];
   int                          name_len  = 0;
   bit                          drop_seen = 1'b0;

   int mismatches   = 0;
   int results_seen = 0;

   lcs_length_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic advance_lcs(input logic [lcs_pkg::CMD_W-1:0] cmd,
                              input logic [lcs_pkg::SYM_W-1:0] sym,
                              output bit emits, output lcs_result_type res);
      logic [lcs_pkg::SCORE_W-1:0] diag;
      logic [lcs_pkg::SCORE_W-1:0] left;
      logic [lcs_pkg::SCORE_W-1:0] prior;
      logic [lcs_pkg::SCORE_W-1:0] now;
      emits = 1'b0;
      res   = '0;
      diag  = '0;
      left  = '0;
      unique case (cmd)
         lcs_pkg::CMD_NAME: begin
            if (name_len == lcs_pkg::MAX_LEN) begin
               drop_seen = 1'b1;
            end else begin
               name_chars[name_len] = sym;
               cell_score[name_len] = (name_len == 0) ? '0 : cell_score[name_len - 1];
               name_len++;
            end
         end
         lcs_pkg::CMD_JOURNAL: begin
            for (int i = 0; i < name_len; i++) begin
               prior = cell_score[i];
               if (name_chars[i] == sym) now = diag + lcs_pkg::SCORE_W'(1);
               else now = (prior > left) ? prior : left;
               diag          = prior;
               left          = now;
               cell_score[i] = now;
            end
         end
         lcs_pkg::CMD_END: begin
            emits   = 1'b1;
            res.len = (name_len == 0) ? '0 : lcs_pkg::LEN_W'(cell_score[name_len - 1]);
            res.ovf = drop_seen;
            for (int i = 0; i < lcs_pkg::MAX_LEN; i++) cell_score[i] = '0;
            name_len  = 0;
            drop_seen = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic add_job(input logic [lcs_pkg::CMD_W-1:0] cmd,
                          input logic [lcs_pkg::SYM_W-1:0] sym,
                          input logic typed, input lcs_result_type res);
      query_item_type job;
      job.cmd   = cmd;
      job.sym   = sym;
      job.typed = typed;
      job.res   = res;
      job_list  = {job_list, job};
   endtask

   function automatic logic [lcs_pkg::SYM_W-1:0] pick_symbol(input bit wide,
                                                            input logic [lcs_pkg::SYM_W-1:0] base);
      // Narrow alphabets give plenty of matches; wide ones exercise every bit.
      if (wide) return lcs_pkg::SYM_W'($urandom_range(0, 255));
      return base ^ lcs_pkg::SYM_W'($urandom_range(0, 3));
   endfunction

   task automatic build_random_queries();
      int                        start;
      int                        names;
      int                        journals;
      int                        late_at;
      bit                        wide;
      logic [lcs_pkg::SYM_W-1:0] base;
      start = job_list.size();
      while ((job_list.size() - start) < RANDOM_ITEMS) begin
         names    = ($urandom_range(0, 11) == 0)
                    ? $urandom_range(lcs_pkg::MAX_LEN - 4, lcs_pkg::MAX_LEN + 6)
                    : $urandom_range(0, 10);
         journals = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 16);
         wide     = ($urandom_range(0, 3) == 0);
         base     = lcs_pkg::SYM_W'($urandom);
         late_at  = (journals > 0 && $urandom_range(0, 5) == 0) ? $urandom_range(0, journals - 1)
                                                                : -1;
         repeat (names) add_job(lcs_pkg::CMD_NAME, pick_symbol(wide, base), 1'b0, '0);
         for (int j = 0; j < journals; j++) begin
            if (j == late_at) add_job(lcs_pkg::CMD_NAME, pick_symbol(wide, base), 1'b0, '0);
            if ($urandom_range(0, 15) == 0) add_job(CMD_SPARE, lcs_pkg::SYM_W'($urandom), 1'b0, '0);
            add_job(lcs_pkg::CMD_JOURNAL, pick_symbol(wide, base), 1'b0, '0);
         end
         add_job(lcs_pkg::CMD_END, lcs_pkg::SYM_W'($urandom), 1'b0, '0);
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: lcs result mismatch: %s", $realtime, what);
   endtask

   initial begin : stimulus
      int             burst_left;
      query_item_type job;
      bit             emits;
      lcs_result_type res;
      foreach (directed[r]) begin
         repeat (directed[r].reps) add_job(directed[r].cmd, directed[r].sym, directed[r].typed,
                                           directed[r].res);
      end
      build_random_queries();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      burst_left = 0;
      foreach (job_list[k]) begin
         job = job_list[k];
         if (burst_left == 0) begin
            // Drop valid for a gap, then start a new burst.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= lcs_pkg::REQ_W'({job.sym, job.cmd});
         do @(posedge clock); while (!req_tready);
         burst_left--;
         advance_lcs(job.cmd, job.sym, emits, res);
         if (emits) pending_lengths = {pending_lengths, (job.typed ? job.res : res)};
      end
      req_tvalid <= 1'b0;

      while (pending_lengths.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : receiver
      ready_pattern_type pattern;
      int                span;
      bit                held;
      held = 1'b0;
      forever begin
         pattern = ready_pattern_type'($urandom_range(0, 3));
         span    = $urandom_range(10, 150);
         repeat (span) begin
            if (!held && results_seen >= 10) begin
               // Hold off long enough for the block to back up onto its input.
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            case (pattern)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               READY_RARELY: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:      rsp_tready <= ~rsp_tready;
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      lcs_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_lengths.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, data %h", rsp_tdata));
         end else begin
            want = pending_lengths.pop_front();
            if (rsp_tdata[lcs_pkg::LEN_W-1:0] !== want.len)
               report_mismatch($sformatf("lcs_length %0d, predicted %0d",
                                         rsp_tdata[lcs_pkg::LEN_W-1:0], want.len));
            if (rsp_tdata[lcs_pkg::LEN_W] !== want.ovf)
               report_mismatch($sformatf("overflow %b, predicted %b",
                                         rsp_tdata[lcs_pkg::LEN_W], want.ovf));
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
